// ===== src/msdl_pkg.sv =====
// shared types and constants for the match sort / dedup / limit block
// no dependencies; imported by every module of the block
package msdl_pkg;

	// configuration register width and reset value
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

	// most results one record can carry
	localparam int MAX_RESULTS = 64;

	// sort key: field order gives the contig, position, strand precedence
	typedef struct packed {
		logic [31:0] contig;
		logic [31:0] position;
		logic [7:0]  strand;
	} key_t;

	// input word
	typedef struct packed {
		logic [31:0] contig;
		logic [31:0] position;
		logic [7:0]  strand;
		logic        has_entry;
		logic        prior_max_reached;
		logic        last;
	} in_word_t;

	// output word
	typedef struct packed {
		logic [31:0] out_contig;
		logic [31:0] out_position;
		logic [7:0]  out_strand;
		logic        out_has_entry;
		logic        max_reached;
		logic [6:0]  unique_count;
		logic        out_last;
	} out_word_t;

	// comparator flags
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ===== src/msdl_store.sv =====
// entry store: one write port, one read port with registered read data
// depends on msdl_pkg (key_t)
module msdl_store import msdl_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  key_t          wr_key,
	input  logic [AW-1:0] rd_addr,
	output key_t          rd_key
);

	key_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_key;
		end
	end

	// registered read port, reads every cycle
	always_ff @(posedge clk) begin
		rd_key <= mem_q[rd_addr];
	end

endmodule

// ===== src/msdl_key_cmp.sv =====
// shared key comparator, used by the sort and the duplicate passes
// depends on msdl_pkg (key_t, cmp_res_t)
module msdl_key_cmp import msdl_pkg::*; (
	input  key_t     a,
	input  key_t     b,
	output cmp_res_t res
);

	// unsigned compare over contig, then position, then strand
	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

// ===== src/match_sort_dedup_limit_core.sv =====
// top level: load sequencer, insertion sort, duplicate removal, limit check, emission
// depends on msdl_pkg, msdl_store, msdl_key_cmp
//
// usage:
// - input channel in_valid / in_ready / in_data carries one record as a run of
//   words, at most one entry each, closed by a word with last set
// - words of a record are taken one per cycle; in_ready drops after the last
//   word until every result of the record has been taken by the output register
// - after the last word the record is insertion sorted in the entry store,
//   then duplicates are removed, then the unique entries leave one by one,
//   each read from the store and then loaded into the output register
// - an upstream saturated, overflowed or empty record gives one result word
//   after its last word, by way of the ST_DECIDE and ST_ONE states
// - the single store port pair gives one read and one write a cycle
// - output channel out_valid / out_ready / out_data is a register; while the
//   receiver stalls the word holds and the sequencer waits
// - cfg_we/cfg_data write the match limit; user keeps to idle, block does not check
// - reset (arst_n low) empties the record and sets the limit to 64; store
//   contents are not cleared, only written entries are ever read
module match_sort_dedup_limit_core import msdl_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;

	// sequencer states
	localparam logic [3:0] ST_LOAD    = 4'd0;
	localparam logic [3:0] ST_DECIDE  = 4'd1;
	localparam logic [3:0] ST_ONE     = 4'd2;
	localparam logic [3:0] ST_S_RDKEY = 4'd3;
	localparam logic [3:0] ST_S_KEY   = 4'd4;
	localparam logic [3:0] ST_S_RD    = 4'd5;
	localparam logic [3:0] ST_S_CMP   = 4'd6;
	localparam logic [3:0] ST_S_PUT   = 4'd7;
	localparam logic [3:0] ST_D_INIT  = 4'd8;
	localparam logic [3:0] ST_D_FIRST = 4'd9;
	localparam logic [3:0] ST_D_RD    = 4'd10;
	localparam logic [3:0] ST_D_CMP   = 4'd11;
	localparam logic [3:0] ST_LIMIT   = 4'd12;
	localparam logic [3:0] ST_E_RD    = 4'd13;
	localparam logic [3:0] ST_E_OUT   = 4'd14;

	logic [3:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             prior_q;
	logic             one_sat_q;
	logic [CFG_W-1:0] limit_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    e_q;
	key_t             key_q;
	key_t             last_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic          in_acc;
	logic          out_free;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	key_t          wr_key;
	logic [AW-1:0] rd_addr;
	key_t          rd_key;
	key_t          cmp_a;
	key_t          cmp_b;
	cmp_res_t      cmp;
	key_t          in_key;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] i_inc;
	logic [AW-1:0] k_inc;
	logic [LW-1:0] uniq;
	logic          too_many;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_LOAD);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_key.contig   = in_data.contig;
	assign in_key.position = in_data.position;
	assign in_key.strand   = in_data.strand;

	assign j_dec = j_q - 1'b1;
	assign i_inc = i_q + 1'b1;
	assign k_inc = k_q + 1'b1;
	assign uniq  = LW'(k_q) + 1'b1;
	assign too_many = (uniq > LW'(limit_q)) || (uniq > LW'(MAX_RESULTS));

	// read address by phase
	always_comb begin
		case (state_q)
			ST_S_RDKEY, ST_S_KEY: rd_addr = i_q[AW-1:0];
			ST_S_RD, ST_S_CMP:    rd_addr = j_dec[AW-1:0];
			ST_D_RD, ST_D_CMP:    rd_addr = i_q[AW-1:0];
			ST_E_RD, ST_E_OUT:    rd_addr = e_q;
			default:              rd_addr = '0;
		endcase
	end

	// shared comparator operands: sort compares key to its left neighbor,
	// duplicate pass compares the next entry to the last kept one
	always_comb begin
		if (state_q == ST_D_CMP) begin
			cmp_a = rd_key;
			cmp_b = last_q;
		end else begin
			cmp_a = key_q;
			cmp_b = rd_key;
		end
	end

	msdl_key_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	// store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_key  = key_q;
		case (state_q)
			ST_LOAD: begin
				wr_en   = in_acc && in_data.has_entry && (cnt_q < CW'(MAX_ENTRIES));
				wr_addr = cnt_q[AW-1:0];
				wr_key  = in_key;
			end
			ST_S_CMP: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_key  = cmp.lt ? rd_key : key_q;
			end
			ST_S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_key  = key_q;
			end
			ST_D_CMP: begin
				wr_en   = !cmp.eq;
				wr_addr = k_inc;
				wr_key  = rd_key;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	msdl_store #(.DEPTH(MAX_ENTRIES)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.rd_addr (rd_addr),
		.rd_key  (rd_key)
	);

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			prior_q     <= 1'b0;
			one_sat_q   <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// take entries of the record
				ST_LOAD: begin
					if (in_acc) begin
						if (in_data.has_entry) begin
							if (cnt_q < CW'(MAX_ENTRIES)) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (in_data.last) begin
							prior_q <= in_data.prior_max_reached;
							state_q <= ST_DECIDE;
						end
					end
				end
				// saturated, empty, single entry or sort
				ST_DECIDE: begin
					if (prior_q || ovf_q) begin
						one_sat_q <= 1'b1;
						state_q   <= ST_ONE;
					end else if (cnt_q == '0) begin
						one_sat_q <= 1'b0;
						state_q   <= ST_ONE;
					end else if (cnt_q == CW'(1)) begin
						state_q <= ST_D_INIT;
					end else begin
						i_q     <= CW'(1);
						state_q <= ST_S_RDKEY;
					end
				end
				// single empty result
				ST_ONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				// insertion sort: fetch the key to place
				ST_S_RDKEY: begin
					state_q <= ST_S_KEY;
				end
				ST_S_KEY: begin
					j_q     <= i_q;
					state_q <= ST_S_RD;
				end
				ST_S_RD: begin
					state_q <= ST_S_CMP;
				end
				// shift the neighbor right or place the key
				ST_S_CMP: begin
					if (cmp.lt) begin
						j_q     <= j_dec;
						state_q <= (j_dec == '0) ? ST_S_PUT : ST_S_RD;
					end else begin
						i_q     <= i_inc;
						state_q <= (i_inc == cnt_q) ? ST_D_INIT : ST_S_RDKEY;
					end
				end
				ST_S_PUT: begin
					i_q     <= i_inc;
					state_q <= (i_inc == cnt_q) ? ST_D_INIT : ST_S_RDKEY;
				end
				// duplicate removal over the sorted store
				ST_D_INIT: begin
					state_q <= ST_D_FIRST;
				end
				ST_D_FIRST: begin
					k_q     <= '0;
					i_q     <= CW'(1);
					state_q <= (cnt_q == CW'(1)) ? ST_LIMIT : ST_D_RD;
				end
				ST_D_RD: begin
					state_q <= ST_D_CMP;
				end
				ST_D_CMP: begin
					if (!cmp.eq) begin
						k_q <= k_inc;
					end
					i_q     <= i_inc;
					state_q <= (i_inc == cnt_q) ? ST_LIMIT : ST_D_RD;
				end
				// limit check on the unique count
				ST_LIMIT: begin
					if (too_many) begin
						one_sat_q <= 1'b1;
						state_q   <= ST_ONE;
					end else begin
						e_q     <= '0;
						state_q <= ST_E_RD;
					end
				end
				// emission of unique entries
				ST_E_RD: begin
					state_q <= ST_E_OUT;
				end
				ST_E_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (e_q == k_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload registers: sort key, last kept entry, output word
	always_ff @(posedge clk) begin
		if (state_q == ST_S_KEY) begin
			key_q <= rd_key;
		end
		if (state_q == ST_D_FIRST || (state_q == ST_D_CMP && !cmp.eq)) begin
			last_q <= rd_key;
		end
		if (state_q == ST_ONE && out_free) begin
			out_q.out_contig    <= '0;
			out_q.out_position  <= '0;
			out_q.out_strand    <= '0;
			out_q.out_has_entry <= 1'b0;
			out_q.max_reached   <= one_sat_q;
			out_q.unique_count  <= '0;
			out_q.out_last      <= 1'b1;
		end else if (state_q == ST_E_OUT && out_free) begin
			out_q.out_contig    <= rd_key.contig;
			out_q.out_position  <= rd_key.position;
			out_q.out_strand    <= rd_key.strand;
			out_q.out_has_entry <= 1'b1;
			out_q.max_reached   <= 1'b0;
			out_q.unique_count  <= uniq[6:0];
			out_q.out_last      <= (e_q == k_q);
		end
	end

endmodule
